// ===== design/bres_pkg.sv =====
// Shared types and microcode table for the Bresenham line rasteriser.
// Holds the sequencer step codes, jump conditions and control word layout.
// No dependencies.
`timescale 1ns / 1ps

package bres_pkg;

  // Default canvas coordinate width
  localparam int COORD_BITS_DEF = 6;

  // Sequencer steps (program addresses)
  typedef enum logic [2:0] {
    STEP_IDLE  = 3'd0,
    STEP_EXT   = 3'd1,
    STEP_ORDER = 3'd2,
    STEP_INIT  = 3'd3,
    STEP_EMIT  = 3'd4,
    STEP_DONE  = 3'd5
  } step_t;

  // Jump conditions: jump to target when true, else fall through
  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_ALWAYS   = 2'd1,
    COND_NO_INPUT = 2'd2,
    COND_MORE     = 2'd3
  } cond_t;

  // One control word of the program
  typedef struct packed {
    logic  in_ld;     // offer in_ready and capture endpoints
    logic  ext_ld;    // compare extents, capture steep flag
    logic  ord_ld;    // order endpoints, capture deltas and start point
    logic  err_ld;    // load initial error term
    logic  emit;      // write a pixel and advance the walk
    cond_t cond;
    step_t target;
  } ctl_word_t;

  // Microcode ROM
  function automatic ctl_word_t ucode_rom(step_t s);
    ctl_word_t w;
    w = '{in_ld: 1'b0, ext_ld: 1'b0, ord_ld: 1'b0, err_ld: 1'b0, emit: 1'b0,
          cond: COND_ALWAYS, target: STEP_IDLE};
    case (s)
      STEP_IDLE: begin
        w.in_ld  = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_EXT: begin
        w.ext_ld = 1'b1;
        w.cond   = COND_NEVER;
      end
      STEP_ORDER: begin
        w.ord_ld = 1'b1;
        w.cond   = COND_NEVER;
      end
      STEP_INIT: begin
        w.err_ld = 1'b1;
        w.cond   = COND_NEVER;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_MORE;
        w.target = STEP_EMIT;
      end
      STEP_DONE: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/bresenham_line_rasterizer.sv =====
// Top level of the Bresenham line rasteriser: microcode sequencer and datapath.
// Depends on bres_pkg for step codes, conditions and the microcode ROM.
// Usage:
//   Input channel (in_valid/in_ready) carries one segment as start_x/start_y
//   and end_x/end_y. Output channel (out_valid/out_ready) carries one pixel
//   per transfer as pixel_x/pixel_y, with last_pixel set on the final one.
//   Pixels come out in order of increasing major coordinate; the major axis
//   is y when the vertical extent is the larger, otherwise x.
//   A segment yields (major extent + 1) pixels, between 1 and 2^COORD_BITS.
//   Timing: in_ready is high only in the idle step. Each segment runs
//   the six-step program: idle, extent compare, endpoint ordering, error
//   set-up, one emit step per pixel, and a closing step. The emit step
//   registers the first pixel, and further pixels follow at one per cycle
//   while the receiver takes them.
//   The output register is loaded whenever it is empty or being taken, so
//   a stalled receiver holds the pixel and the emit step waits in place.
//   Reset returns the step counter to idle and empties the output register.
`timescale 1ns / 1ps

module bresenham_line_rasterizer #(
  parameter int COORD_BITS = bres_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last_pixel
);
  import bres_pkg::*;

  localparam int EW = COORD_BITS + 3;

  step_t                  step;
  step_t                  step_next;
  ctl_word_t              ctl;

  logic [COORD_BITS-1:0]  ax, ay, bx, by;
  logic                   steep;
  logic [COORD_BITS-1:0]  maj, mn, maj_end, dmaj, dmin;
  logic                   step_up;
  logic signed [EW-1:0]   err;

  logic [COORD_BITS-1:0]  adx, ady;
  logic [COORD_BITS-1:0]  maj0, min0, maj1, min1, sa_maj, sa_min, sb_maj, sb_min;
  logic signed [EW-1:0]   two_dmin, two_dmaj, err_next;
  logic                   out_free, fire, at_end, cond_hit;

  // Decode current control word
  always_comb begin
    ctl = ucode_rom(step);
  end

  assign out_free = !out_valid || out_ready;
  assign fire     = ctl.emit && out_free;
  assign at_end   = (maj == maj_end);
  assign in_ready = ctl.in_ld;

  // Jump condition and next step
  always_comb begin
    case (ctl.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_NO_INPUT: cond_hit = !in_valid;
      COND_MORE:     cond_hit = !(fire && at_end);
      default:       cond_hit = 1'b1;
    endcase
    step_next = cond_hit ? ctl.target : step_t'(step + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Extents of the captured segment
  assign adx = (bx > ax) ? bx - ax : ax - bx;
  assign ady = (by > ay) ? by - ay : ay - by;

  // Pick major/minor axes, then order so the major coordinate counts up
  always_comb begin
    sa_maj = steep ? ay : ax;
    sa_min = steep ? ax : ay;
    sb_maj = steep ? by : bx;
    sb_min = steep ? bx : by;
    if (sb_maj < sa_maj) begin
      maj0 = sb_maj; min0 = sb_min; maj1 = sa_maj; min1 = sa_min;
    end else begin
      maj0 = sa_maj; min0 = sa_min; maj1 = sb_maj; min1 = sb_min;
    end
  end

  // Error term arithmetic
  assign two_dmin = $signed({2'b00, dmin, 1'b0});
  assign two_dmaj = $signed({2'b00, dmaj, 1'b0});
  assign err_next = (err > $signed({EW{1'b0}})) ? err + two_dmin - two_dmaj
                                                : err + two_dmin;

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctl.in_ld && in_valid) begin
      ax <= start_x;
      ay <= start_y;
      bx <= end_x;
      by <= end_y;
    end
    if (ctl.ext_ld) begin
      steep <= (ady > adx);
    end
    if (ctl.ord_ld) begin
      maj     <= maj0;
      mn      <= min0;
      maj_end <= maj1;
      dmaj    <= maj1 - maj0;
      dmin    <= (min1 > min0) ? min1 - min0 : min0 - min1;
      step_up <= (min0 < min1);
    end
    if (ctl.err_ld) begin
      err <= two_dmin - $signed({3'b000, dmaj});
    end else if (fire) begin
      err <= err_next;
      maj <= maj + 1'b1;
      if (err > $signed({EW{1'b0}})) begin
        mn <= step_up ? mn + 1'b1 : mn - 1'b1;
      end
    end
  end

  // Output register: load on emit, drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pixel_x    <= steep ? mn : maj;
      pixel_y    <= steep ? maj : mn;
      last_pixel <= at_end;
    end
  end

endmodule

// ===== design/bres_checker.sv =====
// Port-level checker for the Bresenham line rasteriser, bound to the top level.
// Depends on bresenham_line_rasterizer port names only.
`timescale 1ns / 1ps

module bres_checker #(
  parameter int COORD_BITS = 6
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] pixel_x,
  input logic [COORD_BITS-1:0] pixel_y,
  input logic                  last_pixel
);

  // Stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) &&
                                $stable(pixel_y) && $stable(last_pixel))
    else $error("stalled pixel changed");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // One segment at a time: no second transfer straight after the first
  a_one_seg: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while segment in progress");

  // When ready for a new segment, any pixel still held is the last one
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> last_pixel)
    else $error("new segment offered before segment finished");

endmodule

bind bresenham_line_rasterizer bres_checker #(.COORD_BITS(COORD_BITS)) u_bres_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .pixel_x(pixel_x),
  .pixel_y(pixel_y), .last_pixel(last_pixel)
);

// ===== tb/tb_bresenham_line_rasterizer.sv =====
// Self-checking testbench for the Bresenham line rasteriser.
// Predicts every pixel of each segment transferred in and checks the pixel stream
// in order. Depends on bres_pkg and bresenham_line_rasterizer.
`timescale 1ns / 1ps

module tb_bresenham_line_rasterizer;

  localparam int CW = bres_pkg::COORD_BITS_DEF;
  localparam int COORD_MAX = (1 << CW) - 1;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // Expected pixel stream and its checker
  class line_scoreboard;
    pixel_t expected_pixels[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Walk the segment along its major axis and queue every pixel
    function void add_segment(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
      int     x0, y0, x1, y1, span_x, span_y;
      int     lo_major, lo_minor, hi_major, hi_minor, swap_tmp;
      int     d_major, d_minor, err, dir, mj, mn;
      bit     steep;
      pixel_t p;
      x0 = sx;
      y0 = sy;
      x1 = ex;
      y1 = ey;
      span_x = (x1 > x0) ? x1 - x0 : x0 - x1;
      span_y = (y1 > y0) ? y1 - y0 : y0 - y1;
      // equal extents keep x as the major axis
      steep = span_y > span_x;
      if (steep) begin
        lo_major = y0; lo_minor = x0; hi_major = y1; hi_minor = x1;
      end else begin
        lo_major = x0; lo_minor = y0; hi_major = x1; hi_minor = y1;
      end
      // order the endpoints so the major coordinate counts up
      if (hi_major < lo_major) begin
        swap_tmp = lo_major; lo_major = hi_major; hi_major = swap_tmp;
        swap_tmp = lo_minor; lo_minor = hi_minor; hi_minor = swap_tmp;
      end
      d_major = hi_major - lo_major;
      d_minor = (hi_minor > lo_minor) ? hi_minor - lo_minor : lo_minor - hi_minor;
      err = 2 * d_minor - d_major;
      dir = (lo_minor < hi_minor) ? 1 : -1;
      mn = lo_minor;
      for (mj = lo_major; mj <= hi_major; mj++) begin
        p.x    = steep ? coord_t'(mn) : coord_t'(mj);
        p.y    = steep ? coord_t'(mj) : coord_t'(mn);
        p.last = (mj == hi_major);
        expected_pixels.push_back(p);
        if (err <= 0) begin
          err += 2 * d_minor;
        end else begin
          mn  += dir;
          err += 2 * (d_minor - d_major);
        end
      end
    endfunction

    // Compare one transferred pixel with the oldest expected one
    function void check_pixel(coord_t px, coord_t py, logic lst);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        if (errors < 10)
          $display("ERROR %0t: unexpected pixel x=%0d y=%0d last=%0b", $realtime, px, py, lst);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      if (px !== want.x || py !== want.y || lst !== want.last) begin
        if (errors < 10)
          $display("ERROR %0t: pixel expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   $realtime, want.x, want.y, want.last, px, py, lst);
        errors++;
      end
    endfunction

    // Record pixels that never arrived
    function void flag_leftover();
      if (expected_pixels.size() != 0) begin
        if (errors < 10)
          $display("ERROR %0t: %0d expected pixels never arrived",
                   $realtime, expected_pixels.size());
        errors++;
      end
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  coord_t start_x = '0;
  coord_t start_y = '0;
  coord_t end_x = '0;
  coord_t end_y = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last_pixel;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  line_scoreboard sb;

  bresenham_line_rasterizer #(.COORD_BITS(CW)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last_pixel(last_pixel)
  );

  always #5 clk = ~clk;

  // Observe transfers on both channels and drive the receiver's back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (in_valid && in_ready)
        sb.add_segment(start_x, start_y, end_x, end_y);
      if (out_valid && out_ready)
        sb.check_pixel(pixel_x, pixel_y, last_pixel);
    end
  end

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  // Offer one segment and hold it until the transfer; called at a rising edge
  task automatic send_segment(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender off until every expected pixel has been transferred
  task automatic drain_pixels();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (sb.pending() != 0 && waited < 20000);
    sb.flag_leftover();
  endtask

  // Random segments: half arbitrary, the rest short, axis-aligned, diagonal and corner mixes
  task automatic send_random_segments(input int count);
    coord_t ax, ay, bx, by;
    int     shape, span;
    for (int i = 0; i < count; i++) begin
      ax = coord_t'($urandom_range(COORD_MAX));
      ay = coord_t'($urandom_range(COORD_MAX));
      bx = coord_t'($urandom_range(COORD_MAX));
      by = coord_t'($urandom_range(COORD_MAX));
      shape = $urandom_range(9);
      case (shape)
        5, 6: begin
          bx = clamp_coord(int'(ax) + $urandom_range(8) - 4);
          by = clamp_coord(int'(ay) + $urandom_range(8) - 4);
        end
        7: begin
          if ($urandom_range(1)) bx = ax;
          else by = ay;
        end
        8: begin
          span = (bx > ax) ? bx - ax : ax - bx;
          by = (int'(ay) + span <= COORD_MAX) ? clamp_coord(int'(ay) + span)
                                               : clamp_coord(int'(ay) - span);
        end
        9: begin
          ax = $urandom_range(1) ? coord_t'(COORD_MAX) : '0;
          ay = $urandom_range(1) ? coord_t'(COORD_MAX) : '0;
          bx = $urandom_range(1) ? coord_t'(COORD_MAX) : '0;
          by = $urandom_range(1) ? coord_t'(COORD_MAX) : '0;
        end
        default: ;
      endcase
      send_segment(ax, ay, bx, by);
    end
  endtask

  // Fail the run if it hangs
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: single points, full-length axes, diagonals, reversed and tie cases
    send_segment(0, 0, 0, 0);
    send_segment(63, 63, 63, 63);
    send_segment(0, 0, 63, 0);
    send_segment(63, 63, 0, 63);
    send_segment(0, 0, 0, 63);
    send_segment(63, 63, 63, 0);
    send_segment(0, 0, 63, 63);
    send_segment(63, 63, 0, 0);
    send_segment(63, 0, 0, 63);
    send_segment(0, 63, 63, 0);
    send_segment(10, 20, 15, 25);
    send_segment(15, 20, 10, 25);
    send_segment(40, 5, 30, 50);
    send_segment(5, 40, 50, 30);
    send_segment(0, 0, 62, 63);
    send_segment(0, 0, 63, 62);
    send_segment(7, 7, 8, 7);
    send_segment(7, 7, 7, 8);
    send_segment(21, 42, 42, 21);
    send_segment(42, 21, 21, 42);
    send_segment(63, 1, 0, 2);
    send_segment(1, 63, 2, 0);

    // Random phases with varying pressure on each side
    send_random_segments(100);
    drain_pixels();
    @(posedge clk);
    send_idle_pct = 61;
    send_random_segments(100);
    drain_pixels();
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    send_random_segments(100);
    drain_pixels();
    @(posedge clk);
    send_idle_pct  = 7;
    recv_stall_pct = 7;
    send_random_segments(110);

    // Let the stream settle, then report
    drain_pixels();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
